// ----- hdl/gps_pkg.sv -----
package gps_pkg;

  localparam int UNIFORM_BITS_DEF = 31;
  localparam int WORD_W           = 31;
  localparam int MAG_W            = 31;
  localparam int SQ_W             = 61;
  localparam int S_W              = 60;
  localparam int LOG_BITS         = 26;
  localparam int LZ_W             = 6;
  localparam int W_W              = 33;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic CFG_MEAN = 1'b0;
  localparam logic CFG_STD  = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] u_sample;
    logic [WORD_W-1:0] v_sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] gauss_value;
    logic               last_of_pair;
  } out_t;

  // squared magnitudes and signs of both words
  typedef struct packed {
    logic [SQ_W-1:0] su;
    logic [SQ_W-1:0] sv;
    logic            un;
    logic            vn;
  } pair_t;

  typedef struct packed {
    pair_t           pr;
    logic [S_W-1:0]  s;
    logic [31:0]     x;
    logic [LZ_W-1:0] lz;
  } norm_t;

  typedef struct packed {
    pair_t          pr;
    logic [S_W-1:0] s;
    logic [31:0]    t;
  } dev_in_t;

endpackage

// ----- hdl/gps_front.sv -----
module gps_front #(
  parameter int UNIFORM_BITS = gps_pkg::UNIFORM_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  gps_pkg::in_t    in_data,
  output logic            out_vld,
  output gps_pkg::norm_t  out_data
);

  localparam int NB = UNIFORM_BITS;
  localparam int DS = gps_pkg::MAG_W;
  localparam int FS = 4;
  localparam int SQ = gps_pkg::SQ_W;
  localparam int SW = gps_pkg::S_W;
  localparam int LW = gps_pkg::LZ_W;
  localparam int NS = 6;
  localparam logic [32:0] MAXV = (33'd1 << UNIFORM_BITS) - 33'd1;
  localparam logic [63:0] MAXW = 64'(MAXV);

  logic [32:0]   raw [0:1];
  logic [33:0]   twice [0:1];
  logic [33:0]   mag [0:1];
  logic          mneg [0:1];
  logic [63:0]   fr_r [0:FS-1][0:1];
  logic [63:0]   fr_nxt [0:FS-1][0:1];
  logic [DS-1:0] fq_r [1:FS][0:1];
  logic [DS-1:0] fq_nxt [1:FS][0:1];
  logic          neg_r [0:FS][0:1];
  logic [FS:0]   dv_r;

  gps_pkg::pair_t sq_r;
  logic           sq_vld_r;
  logic [SQ:0]    s_sum;
  logic           s_ok;

  logic [63:0]    w_r [0:NS];
  logic [63:0]    w_nxt [1:NS];
  logic [LW-1:0]  lz_r [0:NS];
  logic [LW-1:0]  lz_nxt [1:NS];
  gps_pkg::pair_t pr_r [0:NS];
  logic [SW-1:0]  s_r [0:NS];
  logic [NS:0]    nv_r;

  // map words to Q1.30 magnitudes; quotient by 2^NB-1 from folding the high part
  // onto the low part (n = a*2^NB + b = a*(2^NB-1) + a + b), one fold a stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      raw[l]   = {2'b00, (l == 0) ? in_data.u_sample : in_data.v_sample} & MAXV;
      twice[l] = {raw[l], 1'b0};
      if (twice[l] >= {1'b0, MAXV}) begin
        mag[l]  = twice[l] - {1'b0, MAXV};
        mneg[l] = 1'b0;
      end else begin
        mag[l]  = {1'b0, MAXV} - twice[l];
        mneg[l] = 1'b1;
      end
      fr_nxt[0][l] = (64'(mag[l]) << 30) + 64'(MAXV >> 1);
      fr_nxt[1][l] = (fr_r[0][l] >> NB) + (fr_r[0][l] & MAXW);
      fq_nxt[1][l] = DS'(fr_r[0][l] >> NB);
      for (int k = 1; k < FS - 1; k++) begin
        fr_nxt[k+1][l] = (fr_r[k][l] >> NB) + (fr_r[k][l] & MAXW);
        fq_nxt[k+1][l] = fq_r[k][l] + DS'(fr_r[k][l] >> NB);
      end
      // folded remainder is now below twice the word range
      if (fr_r[FS-1][l] >= MAXW) begin
        fq_nxt[FS][l] = fq_r[FS-1][l] + DS'(1);
      end else begin
        fq_nxt[FS][l] = fq_r[FS-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r     <= '0;
      sq_vld_r <= 1'b0;
      nv_r     <= '0;
    end else if (adv) begin
      dv_r     <= {dv_r[FS-1:0], in_vld};
      sq_vld_r <= dv_r[FS];
      nv_r     <= {nv_r[NS-1:0], sq_vld_r & s_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < FS; k++) begin
          fr_r[k][l] <= fr_nxt[k][l];
        end
        for (int k = 1; k <= FS; k++) begin
          fq_r[k][l] <= fq_nxt[k][l];
        end
        neg_r[0][l] <= mneg[l];
        for (int k = 0; k < FS; k++) begin
          neg_r[k+1][l] <= neg_r[k][l];
        end
      end
      sq_r.su <= SQ'(64'(fq_r[FS][0]) * 64'(fq_r[FS][0]));
      sq_r.sv <= SQ'(64'(fq_r[FS][1]) * 64'(fq_r[FS][1]));
      sq_r.un <= neg_r[FS][0];
      sq_r.vn <= neg_r[FS][1];
    end
  end

  // reject s == 0 and s >= 1.0
  assign s_sum = {1'b0, sq_r.su} + {1'b0, sq_r.sv};
  assign s_ok  = (s_sum != '0) && (s_sum[SQ:SW] == '0);

  // leading-zero normalization in halving steps
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if ((w_r[k] >> (64 - (32 >> k))) == 64'd0) begin
        w_nxt[k+1]  = w_r[k] << (32 >> k);
        lz_nxt[k+1] = lz_r[k] + LW'(32 >> k);
      end else begin
        w_nxt[k+1]  = w_r[k];
        lz_nxt[k+1] = lz_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r[0]  <= {{(64 - SW){1'b0}}, s_sum[SW-1:0]};
      lz_r[0] <= '0;
      pr_r[0] <= sq_r;
      s_r[0]  <= s_sum[SW-1:0];
      for (int k = 0; k < NS; k++) begin
        w_r[k+1]  <= w_nxt[k+1];
        lz_r[k+1] <= lz_nxt[k+1];
        pr_r[k+1] <= pr_r[k];
        s_r[k+1]  <= s_r[k];
      end
    end
  end

  assign out_vld     = nv_r[NS];
  assign out_data.pr = pr_r[NS];
  assign out_data.s  = s_r[NS];
  assign out_data.x  = w_r[NS][63:32];
  assign out_data.lz = lz_r[NS];

endmodule

// ----- hdl/gps_log.sv -----
module gps_log (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  gps_pkg::norm_t    in_data,
  output logic              out_vld,
  output gps_pkg::dev_in_t  out_data
);

  localparam int LB = gps_pkg::LOG_BITS;

  gps_pkg::norm_t n_r [0:LB];
  gps_pkg::norm_t n_nxt [1:LB];
  logic [LB-1:0]  f_r [0:LB];
  logic [LB-1:0]  f_nxt [1:LB];
  logic [63:0]    sqx [0:LB-1];
  logic [32:0]    y [0:LB-1];
  logic [LB:0]    lv_r;

  gps_pkg::pair_t pr_r [0:2];
  logic [gps_pkg::S_W-1:0] s_r [0:2];
  logic [31:0]    l_r;
  logic [63:0]    pm_r;
  logic [31:0]    t_r;
  logic [2:0]     tv_r;
  logic [64:0]    t_sum;

  // one fraction bit of log2(x) per stage by squaring
  always_comb begin
    for (int k = 0; k < LB; k++) begin
      sqx[k]        = 64'(n_r[k].x) * 64'(n_r[k].x);
      y[k]          = sqx[k][63:31];
      n_nxt[k+1]    = n_r[k];
      n_nxt[k+1].x  = y[k][32] ? y[k][32:1] : y[k][31:0];
      f_nxt[k+1]    = {f_r[k][LB-2:0], y[k][32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
      tv_r <= '0;
    end else if (adv) begin
      lv_r <= {lv_r[LB-1:0], in_vld};
      tv_r <= {tv_r[1:0], lv_r[LB]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[0] <= in_data;
      f_r[0] <= '0;
      for (int k = 0; k < LB; k++) begin
        n_r[k+1] <= n_nxt[k+1];
        f_r[k+1] <= f_nxt[k+1];
      end
      // -log2(s) in Q.26
      l_r     <= ((32'(n_r[LB].lz) - 32'd3) << LB) - 32'(f_r[LB]);
      pr_r[0] <= n_r[LB].pr;
      s_r[0]  <= n_r[LB].s;
      pm_r    <= 64'(l_r) * 64'(gps_pkg::LN2_Q32);
      pr_r[1] <= pr_r[0];
      s_r[1]  <= s_r[0];
      t_r     <= t_sum[63:32];
      pr_r[2] <= pr_r[1];
      s_r[2]  <= s_r[1];
    end
  end

  assign t_sum = {1'b0, pm_r} + (65'd1 << 31);

  assign out_vld     = tv_r[2];
  assign out_data.pr = pr_r[2];
  assign out_data.s  = s_r[2];
  assign out_data.t  = t_r;

endmodule

// ----- hdl/gps_dev.sv -----
module gps_dev (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  gps_pkg::dev_in_t   in_data,
  input  logic signed [31:0] mean_value,
  input  logic [30:0]        std_dev,
  output logic               out_vld,
  output logic [31:0]        g0,
  output logic [31:0]        g1
);

  localparam int SQ = gps_pkg::SQ_W;
  localparam int SW = gps_pkg::S_W;
  localparam int WW = gps_pkg::W_W;
  localparam int DN = WW - 1;
  localparam int RN = 32;

  logic [SQ-1:0] a_in [0:1];
  logic          q0 [0:1];
  logic [SQ-1:0] rm_r [0:DN][0:1];
  logic [SQ-1:0] rm_nxt [1:DN][0:1];
  logic [WW-1:0] wq_r [0:DN][0:1];
  logic [WW-1:0] wq_nxt [1:DN][0:1];
  logic [SQ:0]   r2 [0:DN-1][0:1];
  logic          ng_r [0:DN][0:1];
  logic [SW-1:0] sb_r [0:DN];
  logic [31:0]   tt_r [0:DN];
  logic [DN:0]   av_r;

  logic [63:0]   np_r [0:1];
  logic          npn_r [0:1];
  logic          np_v_r;

  logic [63:0]   sn_r [0:RN][0:1];
  logic [63:0]   sr_r [0:RN][0:1];
  logic [63:0]   sn_nxt [1:RN][0:1];
  logic [63:0]   sr_nxt [1:RN][0:1];
  logic [63:0]   trial [0:RN-1][0:1];
  logic          sg_r [0:RN][0:1];
  logic [RN:0]   qv_r;

  logic [30:0]   zm [0:1];
  logic [61:0]   mp_r [0:1];
  logic          mpn_r [0:1];
  logic          mp_v_r;

  logic [35:0]   qv [0:1];
  logic signed [37:0] val [0:1];
  logic [31:0]   sat [0:1];
  logic [31:0]   g_r [0:1];
  logic          g_v_r;

  assign a_in[0] = in_data.pr.su;
  assign a_in[1] = in_data.pr.sv;

  // u^2 / s as Q1.32, restoring, one bit a stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q0[l] = a_in[l] >= SQ'(in_data.s);
      for (int k = 0; k < DN; k++) begin
        r2[k][l] = {rm_r[k][l], 1'b0};
        if (r2[k][l] >= (SQ + 1)'(sb_r[k])) begin
          rm_nxt[k+1][l] = SQ'(r2[k][l] - (SQ + 1)'(sb_r[k]));
          wq_nxt[k+1][l] = {wq_r[k][l][WW-2:0], 1'b1};
        end else begin
          rm_nxt[k+1][l] = SQ'(r2[k][l]);
          wq_nxt[k+1][l] = {wq_r[k][l][WW-2:0], 1'b0};
        end
      end
    end
  end

  // floor square root, one result bit a stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < RN; k++) begin
        trial[k][l] = sr_r[k][l] + (64'd1 << (62 - 2 * k));
        if (sn_r[k][l] >= trial[k][l]) begin
          sn_nxt[k+1][l] = sn_r[k][l] - trial[k][l];
          sr_nxt[k+1][l] = (sr_r[k][l] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          sn_nxt[k+1][l] = sn_r[k][l];
          sr_nxt[k+1][l] = sr_r[k][l] >> 1;
        end
      end
      zm[l] = (sr_r[RN][l] > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sr_r[RN][l][30:0];
      qv[l] = 36'((64'(mp_r[l]) + (64'd1 << 26)) >> 27);
      if (mpn_r[l]) begin
        val[l] = $signed({{6{mean_value[31]}}, mean_value}) - $signed({2'b00, qv[l]});
      end else begin
        val[l] = $signed({{6{mean_value[31]}}, mean_value}) + $signed({2'b00, qv[l]});
      end
      if (val[l] > 38'sd2147483647) begin
        sat[l] = 32'h7FFF_FFFF;
      end else if (val[l] < -38'sd2147483648) begin
        sat[l] = 32'h8000_0000;
      end else begin
        sat[l] = val[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r   <= '0;
      np_v_r <= 1'b0;
      qv_r   <= '0;
      mp_v_r <= 1'b0;
      g_v_r  <= 1'b0;
    end else if (adv) begin
      av_r   <= {av_r[DN-1:0], in_vld};
      np_v_r <= av_r[DN];
      qv_r   <= {qv_r[RN-1:0], np_v_r};
      mp_v_r <= qv_r[RN];
      g_v_r  <= mp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= in_data.s;
      tt_r[0] <= in_data.t;
      for (int k = 0; k < DN; k++) begin
        sb_r[k+1] <= sb_r[k];
        tt_r[k+1] <= tt_r[k];
      end
      for (int l = 0; l < 2; l++) begin
        rm_r[0][l] <= q0[l] ? a_in[l] - SQ'(in_data.s) : a_in[l];
        wq_r[0][l] <= WW'(q0[l]);
        ng_r[0][l] <= (l == 0) ? in_data.pr.un : in_data.pr.vn;
        for (int k = 0; k < DN; k++) begin
          rm_r[k+1][l] <= rm_nxt[k+1][l];
          wq_r[k+1][l] <= wq_nxt[k+1][l];
          ng_r[k+1][l] <= ng_r[k][l];
        end
        np_r[l]     <= 64'((65'(tt_r[DN]) * 65'(wq_r[DN][l])) >> 3);
        npn_r[l]    <= ng_r[DN][l];
        sn_r[0][l]  <= np_r[l];
        sr_r[0][l]  <= '0;
        sg_r[0][l]  <= npn_r[l];
        for (int k = 0; k < RN; k++) begin
          sn_r[k+1][l] <= sn_nxt[k+1][l];
          sr_r[k+1][l] <= sr_nxt[k+1][l];
          sg_r[k+1][l] <= sg_r[k][l];
        end
        mp_r[l]  <= 62'(zm[l]) * 62'(std_dev);
        mpn_r[l] <= sg_r[RN][l];
        g_r[l]   <= sat[l];
      end
    end
  end

  assign out_vld = g_v_r;
  assign g0      = g_r[0];
  assign g1      = g_r[1];

endmodule

// ----- hdl/gaussian_polar_sampler.sv -----
// Marsaglia polar Gaussian sampler. Each input transfer carries a pair of raw
// uniform words; a pair whose radius s falls outside (0,1) is dropped, any
// other gives two deviates mean + z*std on the result channel, the second
// flagged last_of_pair. The datapath is a fully pipelined chain: word mapping
// by folding against the word range, leading-zero normalize, 26 squaring stages
// for log2, restoring divide and bit-serial square root per word, then scale
// and saturate. Since both deviates leave on one channel, the pipeline stalls,
// and no new pair is accepted, while the output holding register still has
// a deviate of its pair to send. cfg_ready is always high; write mean_value
// (index 0) and std_dev (index 1) only when idle.
module gaussian_polar_sampler #(
  parameter int UNIFORM_BITS = gps_pkg::UNIFORM_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gps_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gps_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_data
);

  logic signed [31:0] mean_r;
  logic [30:0]        std_r;

  logic               adv;
  logic               fr_vld;
  gps_pkg::norm_t     fr_data;
  logic               lg_vld;
  gps_pkg::dev_in_t   lg_data;
  logic               dv_vld;
  logic [31:0]        dv_g0;
  logic [31:0]        dv_g1;

  logic               pv_r;
  logic               sel_r;
  logic [31:0]        g0_r;
  logic [31:0]        g1_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      std_r  <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gps_pkg::CFG_MEAN: mean_r <= cfg_data;
        gps_pkg::CFG_STD:  std_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; it stalls while a pair is still being sent
  assign adv      = !pv_r || (sel_r && out_ready);
  assign in_ready = adv;

  gps_front #(
    .UNIFORM_BITS(UNIFORM_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_data (in_data),
    .out_vld (fr_vld),
    .out_data(fr_data)
  );

  gps_log u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (fr_vld),
    .in_data (fr_data),
    .out_vld (lg_vld),
    .out_data(lg_data)
  );

  gps_dev u_dev (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (lg_vld),
    .in_data   (lg_data),
    .mean_value(mean_r),
    .std_dev   (std_r),
    .out_vld   (dv_vld),
    .g0        (dv_g0),
    .g1        (dv_g1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      sel_r <= 1'b0;
    end else if (adv) begin
      pv_r  <= dv_vld;
      sel_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g0_r <= dv_g0;
      g1_r <= dv_g1;
    end
  end

  assign out_valid             = pv_r;
  assign out_data.gauss_value  = sel_r ? g1_r : g0_r;
  assign out_data.last_of_pair = sel_r;

`ifndef NO_ASSERTIONS
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_pair) |=>
      (out_valid && out_data.last_of_pair))
    else $error("second deviate did not follow the first");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_pair) |-> !in_ready)
    else $error("input taken while first deviate pending");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_of_pair && !dv_vld) |=> !out_valid)
    else $error("result shown with no pair from the pipeline");
`endif

endmodule
